// File: hdl/pgrg_pkg.sv
// ----------------------------------------------------------------------------
// pgrg_pkg
// Shared types and constants of the PWM group rate guard.
// ----------------------------------------------------------------------------
package pgrg_pkg;

	localparam int CHANNEL_COUNT      = 16;
	localparam int GROUP_COUNT        = 4;
	localparam int CHANNELS_PER_GROUP = 4;
	localparam int CH_W               = 4;
	localparam int GRP_W              = 2;
	localparam int NS_W               = 31;
	localparam int VAL_W              = 16;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 16;
	localparam int IN_DATA_W          = 72;
	localparam int OUT_DATA_W         = 24;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [VAL_W-1:0] START_RATE  = 16'd50;
	localparam logic [NS_W-1:0]  NS_PER_S    = 31'd1000000000;
	// duty_ns / 1000 as ((duty_ns >> 3) * US_RECIP) >> US_SHIFT, exact below DUTY_SAT_NS
	localparam logic [NS_W-1:0]  DUTY_SAT_NS = 31'd65536000;
	localparam logic [23:0]      US_RECIP    = 24'd8589935;
	localparam int               US_SHIFT    = 30;

	typedef enum logic [2:0] {
		OP_CONFIG  = 3'd0,
		OP_DISABLE = 3'd1,
		OP_UPDATE  = 3'd2,
		OP_FORCE   = 3'd3,
		OP_TICK    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		WK_CLEAR   = 3'd0,
		WK_GROUP   = 3'd1,
		WK_ALT     = 3'd2,
		WK_DEFAULT = 3'd3,
		WK_DUTY    = 3'd4,
		WK_PIN     = 3'd5
	} write_kind_t;

	typedef enum logic [1:0] {
		CFG_MODE   = 2'd0,
		CFG_IGNORE = 2'd1,
		CFG_ARM    = 2'd2,
		CFG_ZHOLD  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIVF,
		BK_DIVD,
		BK_APPLY,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		op_t             op;
		logic [CH_W-1:0] channel;
		logic [NS_W-1:0] duty_ns;
		logic [NS_W-1:0] per_ns;
	} cmd_t;

endpackage

// File: hdl/pgrg_front.sv
// ----------------------------------------------------------------------------
// pgrg_front
// Accepts input transactions, drops those that cannot act, forms commands.
// ----------------------------------------------------------------------------
module pgrg_front (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pgrg_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [2:0]                      s_tuser,
	output logic                            push,
	output pgrg_pkg::cmd_t                  push_cmd,
	input  logic                            push_ready
);
	import pgrg_pkg::*;

	logic keep;

	always_comb begin
		push_cmd.op      = op_t'(s_tuser);
		push_cmd.channel = s_tdata[CH_W-1:0];
		push_cmd.duty_ns = s_tdata[CH_W+NS_W-1:CH_W];
		push_cmd.per_ns  = s_tdata[CH_W+2*NS_W-1:CH_W+NS_W];
		case (s_tuser)
			OP_CONFIG:  keep = (push_cmd.per_ns != '0);
			OP_DISABLE: keep = 1'b1;
			OP_UPDATE:  keep = 1'b1;
			OP_FORCE:   keep = 1'b1;
			OP_TICK:    keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	// drop transactions without effect without waiting on the queue
	assign s_tready = push_ready || !keep;
	assign push     = s_tvalid && keep && push_ready;

endmodule

// File: hdl/pgrg_queue.sv
// ----------------------------------------------------------------------------
// pgrg_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module pgrg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pgrg_pkg::cmd_t push_cmd,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output pgrg_pkg::cmd_t pop_cmd
);
	import pgrg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign push_ready = (cnt_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

// File: hdl/pgrg_div.sv
// ----------------------------------------------------------------------------
// pgrg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgrg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pgrg_pkg::NS_W-1:0]  dividend,
	input  logic [pgrg_pkg::NS_W-1:0]  divisor,
	output logic                       done,
	output logic [pgrg_pkg::NS_W-1:0]  quotient
);
	import pgrg_pkg::*;

	localparam int CNT_W = $clog2(NS_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NS_W-1:0]  rem_q;
	logic [NS_W-1:0]  dvd_q;
	logic [NS_W-1:0]  dsr_q;
	logic [NS_W:0]    rem_sh;
	logic [NS_W:0]    diff;
	logic             ge;

	assign rem_sh   = {rem_q, dvd_q[NS_W-1]};
	assign diff     = rem_sh - {1'b0, dsr_q};
	assign ge       = (rem_sh >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NS_W-1:0] : rem_sh[NS_W-1:0];
			dvd_q <= {dvd_q[NS_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NS_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/pgrg_back.sv
// ----------------------------------------------------------------------------
// pgrg_back
// Executes commands: rate and duty bookkeeping, result sequencing.
// ----------------------------------------------------------------------------
module pgrg_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pgrg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgrg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               q_valid,
	input  pgrg_pkg::cmd_t                     q_cmd,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pgrg_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [2:0]                         m_tuser,
	output logic                               m_tlast
);
	import pgrg_pkg::*;

	back_state_t      state_q, state_d;
	logic             mode_q;
	logic [15:0]      ignore_q;
	logic [15:0]      arm_win_q;
	logic [7:0]       zhold_q;

	cmd_t             item_q;
	logic [VAL_W-1:0] f_q;
	logic [VAL_W-1:0] d_q;
	logic [VAL_W-1:0] duty_mem [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] nz_q;
	logic [VAL_W-1:0] grp_rate_q [GROUP_COUNT];
	logic [VAL_W-1:0] pend_rate_q [GROUP_COUNT];
	logic [GROUP_COUNT-1:0] flags_q;
	logic [VAL_W-1:0] alt_q;
	logic [VAL_W-1:0] def_q;
	logic [1:0]       leg_q;
	logic [15:0]      arm_q;
	logic             clr_q;
	logic [15:0]      zc_q;
	logic [CH_W-1:0]  emit_idx_q;

	logic             ov_q;
	write_kind_t      okind_q;
	logic [CH_W-1:0]  otgt_q;
	logic [VAL_W-1:0] oval_q;
	logic             olast_q;

	logic             out_free;
	logic             div_start;
	logic [NS_W-1:0]  div_dvd;
	logic [NS_W-1:0]  div_dsr;
	logic             div_done;
	logic [NS_W-1:0]  div_q;
	logic [VAL_W-1:0] div_sat;

	logic [22:0]      d_div8;
	logic [46:0]      d_prod;
	logic [VAL_W-1:0] duty_us;

	logic [16:0]      zc_sum;
	logic [15:0]      zc_eff;
	logic             some;
	logic             armed;
	logic             upd_clear, upd_grp, upd_alt, upd_def, upd_fall;
	logic [GRP_W-1:0] low_grp;
	logic             ign_hit;

	logic [GRP_W-1:0] a_grp;
	logic             a_pin;
	logic             a_stop;
	logic             a_change;
	logic             a_ok;
	logic             a_alt_set;
	logic             a_def_set;

	pgrg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	assign div_sat  = (div_q > NS_W'(16'hFFFF)) ? 16'hFFFF : div_q[VAL_W-1:0];
	assign out_free = !ov_q || m_tready;

	assign d_div8  = item_q.duty_ns[25:3];
	assign d_prod  = {24'd0, d_div8} * {23'd0, US_RECIP};
	assign duty_us = (item_q.duty_ns >= DUTY_SAT_NS) ? 16'hFFFF :
		d_prod[US_SHIFT+VAL_W-1:US_SHIFT];

	always_comb begin
		zc_sum = {1'b0, zc_q} + ((q_cmd.op == OP_FORCE) ? {9'd0, zhold_q} : 17'd0);
		zc_eff = zc_sum[16] ? 16'hFFFF : zc_sum[15:0];
		some   = (leg_q != '0) || (flags_q != '0);
		armed  = (arm_q != '0);
		low_grp = '0;
		for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
			if (flags_q[i]) begin
				low_grp = GRP_W'(i);
			end
		end
		upd_clear = armed && some && !clr_q;
		upd_grp   = armed && !upd_clear && mode_q && (flags_q != '0);
		upd_alt   = armed && !upd_clear && !mode_q && leg_q[0];
		upd_def   = armed && !upd_clear && !mode_q && !leg_q[0] && leg_q[1];
		upd_fall  = !(upd_clear || upd_grp || upd_alt || upd_def);
		ign_hit   = (ignore_q[q_cmd.channel] && (q_cmd.duty_ns != '0)) || (zc_q != '0);
	end

	always_comb begin
		a_grp     = item_q.channel[CH_W-1:CH_W-GRP_W];
		a_pin     = (item_q.channel[CH_W-GRP_W-1:0] == '0);
		a_stop    = (nz_q[a_grp*CHANNELS_PER_GROUP +: CHANNELS_PER_GROUP] == '0);
		a_change  = (grp_rate_q[a_grp] != f_q) && (a_pin || a_stop);
		a_alt_set = !item_q.channel[CH_W-1] && (f_q != alt_q) &&
			(item_q.duty_ns != '0) && a_pin;
		a_def_set = item_q.channel[CH_W-1] && (f_q != def_q) &&
			(item_q.duty_ns != '0) && a_pin;
		if (mode_q) begin
			a_ok = (grp_rate_q[a_grp] == f_q);
		end else if (!item_q.channel[CH_W-1]) begin
			a_ok = a_alt_set || (f_q == alt_q);
		end else begin
			a_ok = a_def_set || (f_q == def_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_dvd   = NS_PER_S;
		div_dsr   = q_cmd.per_ns;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_cmd.op == OP_CONFIG && !ign_hit) begin
						div_start = 1'b1;
						state_d   = BK_DIVF;
					end else if ((q_cmd.op == OP_UPDATE || q_cmd.op == OP_FORCE) &&
						upd_fall && armed && !some) begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_DIVF: begin
				if (div_done) begin
					state_d = BK_DIVD;
				end
			end
			BK_DIVD: begin
				state_d = BK_APPLY;
			end
			BK_APPLY: begin
				state_d = BK_IDLE;
			end
			BK_EMIT: begin
				if (out_free && emit_idx_q == CH_W'(CHANNEL_COUNT-1)) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			ignore_q  <= '0;
			arm_win_q <= 16'd10;
			zhold_q   <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   mode_q    <= cfg_wdata[0];
				CFG_IGNORE: ignore_q  <= cfg_wdata;
				CFG_ARM:    arm_win_q <= cfg_wdata;
				CFG_ZHOLD:  zhold_q   <= cfg_wdata[7:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_cmd;
		end
		if (state_q == BK_DIVF && div_done) begin
			f_q <= div_sat;
		end
		if (state_q == BK_DIVD) begin
			d_q <= duty_us;
		end
		if (state_q == BK_APPLY) begin
			duty_mem[item_q.channel] <= d_q;
		end
		if (out_free) begin
			if (state_q == BK_EMIT) begin
				okind_q <= WK_DUTY;
				otgt_q  <= emit_idx_q;
				oval_q  <= nz_q[emit_idx_q] ? duty_mem[emit_idx_q] : '0;
				olast_q <= (emit_idx_q == CH_W'(CHANNEL_COUNT-1));
			end else if (q_pop) begin
				otgt_q  <= '0;
				oval_q  <= '0;
				olast_q <= 1'b1;
				if (q_cmd.op == OP_DISABLE) begin
					okind_q <= WK_PIN;
					otgt_q  <= q_cmd.channel;
				end else if (upd_clear) begin
					okind_q <= WK_CLEAR;
				end else if (upd_grp) begin
					okind_q <= WK_GROUP;
					otgt_q  <= CH_W'(low_grp);
					oval_q  <= pend_rate_q[low_grp];
				end else if (upd_alt) begin
					okind_q <= WK_ALT;
					oval_q  <= alt_q;
				end else begin
					okind_q <= WK_DEFAULT;
					oval_q  <= def_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q       <= '0;
			flags_q    <= '0;
			alt_q      <= START_RATE;
			def_q      <= START_RATE;
			leg_q      <= '0;
			arm_q      <= '0;
			clr_q      <= 1'b0;
			zc_q       <= '0;
			emit_idx_q <= '0;
			ov_q       <= 1'b0;
			for (int i = 0; i < GROUP_COUNT; i++) begin
				grp_rate_q[i]  <= START_RATE;
				pend_rate_q[i] <= START_RATE;
			end
		end else begin
			if (m_tready) begin
				ov_q <= 1'b0;
			end
			if (state_q == BK_EMIT && out_free) begin
				ov_q       <= 1'b1;
				emit_idx_q <= emit_idx_q + 1'b1;
			end
			if (q_pop) begin
				emit_idx_q <= '0;
				case (q_cmd.op)
					OP_CONFIG: begin
						if (ign_hit) begin
							nz_q[q_cmd.channel] <= 1'b0;
						end else begin
							arm_q <= arm_win_q;
						end
					end
					OP_DISABLE: begin
						nz_q[q_cmd.channel] <= 1'b0;
						arm_q <= '0;
						ov_q  <= 1'b1;
					end
					OP_UPDATE, OP_FORCE: begin
						zc_q <= zc_eff;
						if (upd_clear) begin
							clr_q <= 1'b1;
							ov_q  <= 1'b1;
						end else if (upd_grp) begin
							grp_rate_q[low_grp] <= pend_rate_q[low_grp];
							flags_q[low_grp]    <= 1'b0;
							ov_q                <= 1'b1;
						end else if (upd_alt) begin
							leg_q[0] <= 1'b0;
							ov_q     <= 1'b1;
						end else if (upd_def) begin
							leg_q[1] <= 1'b0;
							ov_q     <= 1'b1;
						end else begin
							clr_q <= 1'b0;
							if (zc_eff != '0) begin
								zc_q <= zc_eff - 1'b1;
								nz_q <= '0;
							end
						end
					end
					OP_TICK: begin
						if (arm_q != '0) begin
							arm_q <= arm_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == BK_APPLY) begin
				nz_q[item_q.channel] <= a_ok && (d_q != '0);
				if (mode_q && a_change) begin
					pend_rate_q[a_grp] <= f_q;
					flags_q[a_grp]     <= 1'b1;
				end
				if (!mode_q && a_alt_set) begin
					alt_q    <= f_q;
					leg_q[0] <= 1'b1;
				end
				if (!mode_q && a_def_set) begin
					def_q    <= f_q;
					leg_q[1] <= 1'b1;
				end
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {(OUT_DATA_W-VAL_W-CH_W)'(0), oval_q, otgt_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == BK_IDLE))
		else $error("command popped while busy");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == BK_DIVF || state_q == BK_DIVD))
		else $error("divider result outside division states");
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT && out_free && emit_idx_q == CH_W'(CHANNEL_COUNT-1))
		|=> (m_tvalid && m_tlast && state_q == BK_IDLE))
		else $error("duty run did not end with last");

endmodule

// File: hdl/pwm_group_rate_guard.sv
// ----------------------------------------------------------------------------
// pwm_group_rate_guard
// Guards 16 PWM duty values in 4 rate groups and sequences output writes.
// ----------------------------------------------------------------------------
// Input stream s_*: one command per transaction, op in s_tuser. Configure
// items with a zero period and unknown ops are taken and dropped at once.
// Output stream m_*: one write per transaction, write kind in m_tuser,
// m_tlast marks the final write caused by a command.
// Configuration: cfg_we writes register cfg_index with cfg_wdata.
// Execution: a configure runs one division for the rate and a
// reciprocal multiply for the duty in the executor; disable, update
// and tick run without a division; a full duty write streams 16
// transactions, one per cycle while the receiver does not stall.
// A two-entry command queue keeps the input side accepting while the
// executor divides or while a result waits on m_tready; the executor
// holds its output register and stalls while the receiver stalls.
// Reset: all duties zero, all rates 50 Hz, outputs disarmed, registers at
// their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pwm_group_rate_guard (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pgrg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgrg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// channel[3:0], duty_ns[34:4], per_ns[65:35]
	input  logic [pgrg_pkg::IN_DATA_W-1:0]     s_tdata,
	// op[2:0]
	input  logic [2:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// target[3:0], write_value[19:4]
	output logic [pgrg_pkg::OUT_DATA_W-1:0]    m_tdata,
	// write_kind[2:0]
	output logic [2:0]                         m_tuser,
	output logic                               m_tlast
);
	import pgrg_pkg::*;

	logic push;
	logic push_ready;
	cmd_t push_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;

	pgrg_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	pgrg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd)
	);

	pgrg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
